// ----- design/assert_macros.svh -----
// Assertion macros shared by the stego extractor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)

`endif

`endif

// ----- design/lse_pkg.sv -----
// Package: types, codes and constants of the LSB stego extractor.
`timescale 1ns / 1ps
`default_nettype none

package lse_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int HEADER_LEN        = 54;
    localparam int OFFSET_FIELD      = 10;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        KIND_CHAR      = 3'd0,
        KIND_TERM      = 3'd1,
        KIND_EOF       = 3'd2,
        KIND_SHORT     = 3'd3,
        KIND_NOPIX     = 3'd4,
        KIND_BADCHAR   = 3'd5,
        KIND_MALFORMED = 3'd6
    } kind_t;

    // One record per input transaction that yields results: an optional
    // character followed by an optional closing result.
    typedef struct packed {
        logic       has_char;
        logic [7:0] char_val;
        logic       has_tail;
        kind_t      tail_kind;
    } lse_rec_t;

    function automatic logic in_alphabet(input logic [7:0] c);
        in_alphabet = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                      (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                      (c == CH_SPACE);
    endfunction

endpackage

`default_nettype wire

// ----- design/lse_front.sv -----
// Front end: header parse, offset skip and LSB gathering, one byte per cycle while the queue is not full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lse_front
    import lse_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] file_byte,
    input  wire logic       end_of_file,
    input  wire logic       q_full,
    output lse_rec_t        rec,
    output logic            rec_push
);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [31:0]              offset_reg, offset_next;
    logic [7:0]               acc_reg, acc_next;
    logic [2:0]               cnt_reg, cnt_next;
    phase_t                   phase_reg, phase_next;

    logic       accept;
    logic       pos_last_hdr;
    logic       hdr_field;
    logic       offset_small;
    logic       off_match;
    logic       in_pixels;
    logic       char_done;
    logic [7:0] acc_upd;
    logic       char_ok;
    logic       stop;
    logic [1:0] lane;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        pos_last_hdr = (pos_reg == POSITION_BITS'(HEADER_LEN - 1));
        hdr_field    = (pos_reg >= POSITION_BITS'(OFFSET_FIELD)) &&
                       (pos_reg <  POSITION_BITS'(OFFSET_FIELD + 4));
        lane         = pos_reg[1:0] + 2'd2;
        offset_small = (offset_reg < 32'(HEADER_LEN));
        off_match    = (32'(pos_reg) == offset_reg);
        in_pixels    = (phase_reg == PH_PIXELS) || (phase_reg == PH_SKIP && off_match);
        char_done    = (cnt_reg == 3'd7);
        acc_upd      = acc_reg | (8'(file_byte[0]) << cnt_reg);
        char_ok      = in_alphabet(acc_upd);
        stop         = in_pixels && char_done && !char_ok;
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (end_of_file)
            begin
                phase_next = PH_HEADER;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (pos_last_hdr)
                        begin
                            phase_next = offset_small ? PH_DONE : PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (off_match)
                        begin
                            phase_next = stop ? PH_DONE : PH_PIXELS;
                        end
                    end
                    PH_PIXELS:
                    begin
                        if (stop)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // result record
    always_comb
    begin
        rec = '0;
        rec.tail_kind = KIND_CHAR;
        case (phase_reg)
            PH_HEADER:
            begin
                if (pos_last_hdr)
                begin
                    if (offset_small)
                    begin
                        rec.has_tail  = 1'b1;
                        rec.tail_kind = KIND_MALFORMED;
                    end
                    else if (end_of_file)
                    begin
                        rec.has_tail  = 1'b1;
                        rec.tail_kind = KIND_NOPIX;
                    end
                end
                else if (end_of_file)
                begin
                    rec.has_tail  = 1'b1;
                    rec.tail_kind = KIND_SHORT;
                end
            end
            PH_SKIP:
            begin
                if (!off_match && end_of_file)
                begin
                    rec.has_tail  = 1'b1;
                    rec.tail_kind = KIND_NOPIX;
                end
            end
            default:
            begin
                rec.has_tail = 1'b0;
            end
        endcase
        if (in_pixels)
        begin
            if (char_done)
            begin
                if (acc_upd == CH_NUL)
                begin
                    rec.has_tail  = 1'b1;
                    rec.tail_kind = KIND_TERM;
                end
                else if (char_ok)
                begin
                    rec.has_char = 1'b1;
                    rec.char_val = acc_upd;
                end
                else
                begin
                    rec.has_tail  = 1'b1;
                    rec.tail_kind = KIND_BADCHAR;
                end
            end
            if (end_of_file && !stop)
            begin
                rec.has_tail  = 1'b1;
                rec.tail_kind = KIND_EOF;
            end
        end
        rec_push = accept && (rec.has_char || rec.has_tail);
    end

    // datapath
    always_comb
    begin
        pos_next    = pos_reg;
        offset_next = offset_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        if (accept)
        begin
            if (end_of_file)
            begin
                pos_next    = '0;
                offset_next = '0;
                acc_next    = '0;
                cnt_next    = '0;
            end
            else
            begin
                if (!(&pos_reg))
                begin
                    pos_next = pos_reg + POSITION_BITS'(1);
                end
                if (phase_reg == PH_HEADER && hdr_field)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (lane == 2'(i))
                        begin
                            offset_next[8*i +: 8] = offset_reg[8*i +: 8] | file_byte;
                        end
                    end
                end
                if (in_pixels)
                begin
                    if (char_done)
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        acc_next = acc_upd;
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            offset_reg <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            phase_reg  <= PH_HEADER;
        end
        else
        begin
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
        end
    end

    `ASSERT_NEXT(a_eof_rearms, clk, rst_n, accept && end_of_file, pos_reg == '0 && phase_reg == PH_HEADER && cnt_reg == 3'd0, "end of file did not rearm the parser")
    `ASSERT_IMPLY(a_char_nonzero, clk, rst_n, rec_push && rec.has_char, rec.char_val != CH_NUL && !(rec.has_tail && rec.tail_kind != KIND_EOF), "bad character record")

endmodule

`default_nettype wire

// ----- design/lse_queue.sv -----
// Record queue between the parsing front end and the result back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lse_queue
    import lse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire lse_rec_t wr_rec,
    output logic          q_full,
    input  wire logic     rd_en,
    output lse_rec_t      rd_rec,
    output logic          q_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    lse_rec_t         entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_rec  = entries_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= (PTR_W+1)'(QUEUE_DEPTH), "queue count overflow")
    `ASSERT_ALWAYS(a_ptr_count, clk, rst_n, PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0], "queue pointers disagree with count")

endmodule

`default_nettype wire

// ----- design/lse_back.sv -----
// Back end: splits each queued record into result transactions.
`timescale 1ns / 1ps
`default_nettype none

module lse_back
    import lse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lse_rec_t   head_rec,
    input  wire logic       q_empty,
    output logic            deq,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      result_kind,
    output logic [7:0]      character,
    output logic            last_result
);

    logic sub_reg, sub_next;
    logic show_char;
    logic take;

    assign empty     = q_empty;
    assign show_char = head_rec.has_char && !sub_reg;
    assign take      = pop && !q_empty;

    always_comb
    begin
        result_kind = show_char ? KIND_CHAR : head_rec.tail_kind;
        character   = show_char ? head_rec.char_val : 8'h00;
        last_result = !show_char;
    end

    always_comb
    begin
        sub_next = sub_reg;
        deq      = 1'b0;
        if (take)
        begin
            if (show_char && head_rec.has_tail)
            begin
                sub_next = 1'b1;
            end
            else
            begin
                sub_next = 1'b0;
                deq      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/lsb_stego_extractor_unit.sv -----
// Top level of the LSB stego extractor: front end, record queue, back end.
`timescale 1ns / 1ps
`default_nettype none

// Streams a BMP file one byte per transaction (end_of_file on the last byte)
// and returns the hidden message: one result per decoded letter or space,
// then a closing result (terminator, end of file, or an error kind) with
// last_result set. A byte is taken every cycle while full is low; the front
// end parses it in that same cycle and writes at most one record into a
// four-entry queue. Results show the cycle after the byte is taken if the
// queue was empty, then one per cycle while pop is high; only a byte that
// both completes a character and ends the file yields two results. full
// rises only when the queue holds four records the consumer has not
// popped. After the final byte the unit is ready for the next file at once.
module lsb_stego_extractor_unit
    import lse_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] file_byte,
    input  wire logic       end_of_file,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      result_kind,
    output logic [7:0]      character,
    output logic            last_result
);

    lse_rec_t rec;
    lse_rec_t head_rec;
    logic     rec_push;
    logic     q_full;
    logic     q_empty;
    logic     deq;

    lse_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .file_byte  (file_byte),
        .end_of_file(end_of_file),
        .q_full     (q_full),
        .rec        (rec),
        .rec_push   (rec_push)
    );

    lse_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (rec_push),
        .wr_rec (rec),
        .q_full (q_full),
        .rd_en  (deq),
        .rd_rec (head_rec),
        .q_empty(q_empty)
    );

    lse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_rec   (head_rec),
        .q_empty    (q_empty),
        .deq        (deq),
        .empty      (empty),
        .pop        (pop),
        .result_kind(result_kind),
        .character  (character),
        .last_result(last_result)
    );

endmodule

`default_nettype wire
